FILE: hw/rtl/dmt_pkg.sv
package dmt_pkg;

    localparam int SYM_W   = 8;
    localparam int STATE_W = 5;
    localparam int ENTRY_W = STATE_W + 1;
    localparam int FLAG_W  = 32;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [STATE_W-1:0] state_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_CHAR   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_TOKEN = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_ERROR = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/dmt_in_if.sv
interface dmt_in_if;
    logic             valid;
    logic             ready;
    dmt_pkg::kind_t   kind;
    dmt_pkg::state_t  from_state;
    dmt_pkg::sym_t    symbol;
    dmt_pkg::state_t  next_state;
    logic             entry_valid;
    logic             accepting;

    modport source (output valid, kind, from_state, symbol, next_state, entry_valid,
                    accepting, input ready);
    modport sink   (input valid, kind, from_state, symbol, next_state, entry_valid,
                    accepting, output ready);
endinterface

FILE: hw/rtl/dmt_out_if.sv
interface dmt_out_if;
    logic             valid;
    logic             ready;
    dmt_pkg::sym_t    out_char;
    logic             token_last;
    dmt_pkg::status_t status;

    modport source (output valid, out_char, token_last, status, input ready);
    modport sink   (input valid, out_char, token_last, status, output ready);
endinterface

FILE: hw/rtl/dmt_ram.sv
module dmt_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] addr,
    input  logic [W-1:0]         wdata,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end
endmodule

FILE: hw/rtl/dfa_maximal_munch_tokenizer_top.sv
// load and accept requests finish in S_IDLE; a character without rewind goes to S_EVAL
// emitted token chars pass S_EMIT_RD, S_EMIT_WR; reprocessed ones S_BUF, S_LOOK, S_EVAL
// end goes to S_ERR, or to S_DONE after the flush; results leave through one output register
// throughput is set by the single port of the transition table memory (one read per step)
// after reset the table is cleared one entry a cycle, all NUM_STATES*256, input held off
// reset clears accept bits, start state and the stream state; the token buffer is not cleared
module dfa_maximal_munch_tokenizer_top #(
    parameter int NUM_STATES = 32,
    parameter int MAX_TOKEN  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  dmt_pkg::state_t   cfg_data,
    dmt_in_if.sink            item,
    dmt_out_if.source         result
);
    import dmt_pkg::*;

    localparam int TD = NUM_STATES * 256;
    localparam int AW = $clog2(TD);
    localparam int BW = $clog2(MAX_TOKEN + 1);
    localparam int BD = 2 ** BW;
    localparam int LW = $clog2(MAX_TOKEN + 2);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EVAL, S_BUF, S_LOOK, S_EMIT_RD, S_EMIT_WR, S_ERR, S_DONE
    } fsm_t;

    fsm_t              st_reg;
    logic [AW-1:0]     clr_reg;
    state_t            start_reg;
    state_t            cur_reg;
    logic [FLAG_W-1:0] acc_reg;
    logic [BW-1:0]     base_reg;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     tot_reg;
    logic [LW-1:0]     i_reg;
    logic [LW-1:0]     k_reg;
    logic [LW-1:0]     lal_reg;
    logic              seen_reg;
    logic              err_reg;
    logic              ending_reg;

    logic              out_valid_reg;
    sym_t              out_char_reg;
    logic              out_last_reg;
    status_t           out_status_reg;

    logic              tbl_en, tbl_we;
    logic [AW-1:0]     tbl_addr;
    entry_t            tbl_wdata, tbl_rdata;
    logic              buf_en, buf_we;
    logic [BW-1:0]     buf_addr;
    sym_t              buf_rdata;

    logic              acc_in;
    logic              slot_free;
    logic              hit;
    logic [LW-1:0]     i_inc;
    logic [LW-1:0]     k_inc;
    logic              load_ok;

    function automatic logic accepts(input state_t s, input logic [FLAG_W-1:0] f);
        return (32'(s) < NUM_STATES) && f[s];
    endfunction

    assign item.ready = (st_reg == S_IDLE);
    assign acc_in     = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign hit        = tbl_rdata[ENTRY_W-1] && (32'(cur_reg) < NUM_STATES);
    assign i_inc      = i_reg + 1'b1;
    assign k_inc      = k_reg + 1'b1;
    assign load_ok    = (32'(item.from_state) < NUM_STATES)
                        && (32'(item.next_state) < NUM_STATES);

    assign result.valid      = out_valid_reg;
    assign result.out_char   = out_char_reg;
    assign result.token_last = out_last_reg;
    assign result.status     = out_status_reg;

    // table port
    always_comb
    begin
        tbl_en    = 1'b0;
        tbl_we    = 1'b0;
        tbl_addr  = AW'({cur_reg, buf_rdata});
        tbl_wdata = '0;
        case (st_reg)
            S_CLEAR:
            begin
                tbl_en   = 1'b1;
                tbl_we   = 1'b1;
                tbl_addr = clr_reg;
            end
            S_IDLE:
            begin
                if (acc_in && item.kind == KIND_LOAD && load_ok)
                begin
                    tbl_en    = 1'b1;
                    tbl_we    = 1'b1;
                    tbl_addr  = AW'({item.from_state, item.symbol});
                    tbl_wdata = item.entry_valid ? {1'b1, item.next_state} : '0;
                end
                else if (acc_in && item.kind == KIND_CHAR && !err_reg)
                begin
                    tbl_en   = 1'b1;
                    tbl_addr = AW'({cur_reg, item.symbol});
                end
            end
            S_LOOK:
                tbl_en = 1'b1;
            default:
                tbl_en = 1'b0;
        endcase
    end

    // token buffer port, circular from base_reg
    always_comb
    begin
        buf_en   = 1'b0;
        buf_we   = 1'b0;
        buf_addr = base_reg + BW'(i_reg);
        case (st_reg)
            S_IDLE:
            begin
                if (acc_in && item.kind == KIND_CHAR && !err_reg)
                begin
                    buf_en   = 1'b1;
                    buf_we   = 1'b1;
                    buf_addr = base_reg + BW'(len_reg);
                end
            end
            S_BUF:
                buf_en = 1'b1;
            S_EMIT_RD:
            begin
                buf_en   = 1'b1;
                buf_addr = base_reg + BW'(k_reg);
            end
            default:
                buf_en = 1'b0;
        endcase
    end

    dmt_ram #(.W(ENTRY_W), .D(TD)) u_table (
        .clk   (clk),
        .en    (tbl_en),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    dmt_ram #(.W(SYM_W), .D(BD)) u_buf (
        .clk   (clk),
        .en    (buf_en),
        .we    (buf_we),
        .addr  (buf_addr),
        .wdata (item.symbol),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            clr_reg       <= '0;
            start_reg     <= '0;
            cur_reg       <= '0;
            acc_reg       <= '0;
            base_reg      <= '0;
            len_reg       <= '0;
            tot_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            lal_reg       <= '0;
            seen_reg      <= 1'b0;
            err_reg       <= 1'b0;
            ending_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                start_reg <= cfg_data;
            if (result.ready)
                out_valid_reg <= 1'b0;

            case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TD - 1))
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (acc_in)
                    begin
                        case (item.kind)
                            KIND_ACCEPT:
                            begin
                                if (32'(item.from_state) < NUM_STATES)
                                    acc_reg[item.from_state] <= item.accepting;
                            end
                            KIND_CHAR:
                            begin
                                if (!err_reg)
                                begin
                                    i_reg   <= len_reg;
                                    tot_reg <= len_reg + 1'b1;
                                    st_reg  <= S_EVAL;
                                end
                            end
                            KIND_END:
                            begin
                                cur_reg    <= start_reg;
                                len_reg    <= '0;
                                err_reg    <= 1'b0;
                                seen_reg   <= 1'b0;
                                ending_reg <= 1'b1;
                                k_reg      <= '0;
                                if (err_reg || (len_reg != '0 && !accepts(cur_reg, acc_reg)))
                                    st_reg <= S_ERR;
                                else if (seen_reg && lal_reg <= len_reg)
                                    st_reg <= S_EMIT_RD;
                                else
                                    st_reg <= S_DONE;
                            end
                            default:
                                st_reg <= S_IDLE;
                        endcase
                    end
                end
                S_EVAL:
                begin
                    if (hit)
                    begin
                        if (32'(i_inc) > MAX_TOKEN)
                        begin
                            err_reg  <= 1'b1;
                            len_reg  <= '0;
                            lal_reg  <= '0;
                            seen_reg <= 1'b0;
                            st_reg   <= S_ERR;
                        end
                        else
                        begin
                            cur_reg <= tbl_rdata[STATE_W-1:0];
                            if (accepts(tbl_rdata[STATE_W-1:0], acc_reg))
                            begin
                                lal_reg  <= i_inc;
                                seen_reg <= 1'b1;
                            end
                            i_reg <= i_inc;
                            if (i_inc == tot_reg)
                            begin
                                len_reg <= tot_reg;
                                st_reg  <= S_IDLE;
                            end
                            else
                                st_reg <= S_BUF;
                        end
                    end
                    else if (seen_reg && lal_reg != '0)
                    begin
                        k_reg      <= '0;
                        ending_reg <= 1'b0;
                        st_reg     <= S_EMIT_RD;
                    end
                    else
                    begin
                        err_reg  <= 1'b1;
                        len_reg  <= '0;
                        lal_reg  <= '0;
                        seen_reg <= 1'b0;
                        st_reg   <= S_ERR;
                    end
                end
                S_BUF:
                    st_reg <= S_LOOK;
                S_LOOK:
                    st_reg <= S_EVAL;
                S_EMIT_RD:
                    st_reg <= S_EMIT_WR;
                S_EMIT_WR:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= buf_rdata;
                        out_last_reg   <= (k_inc == lal_reg);
                        out_status_reg <= STAT_TOKEN;
                        k_reg          <= k_inc;
                        if (k_inc == lal_reg)
                        begin
                            if (ending_reg)
                                st_reg <= S_DONE;
                            else
                            begin
                                // rewind: restart from start state after the token
                                base_reg <= base_reg + BW'(lal_reg);
                                tot_reg  <= tot_reg - lal_reg;
                                i_reg    <= '0;
                                cur_reg  <= start_reg;
                                seen_reg <= 1'b0;
                                lal_reg  <= '0;
                                st_reg   <= S_BUF;
                            end
                        end
                        else
                            st_reg <= S_EMIT_RD;
                    end
                end
                S_ERR:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= '0;
                        out_last_reg   <= 1'b0;
                        out_status_reg <= STAT_ERROR;
                        st_reg         <= S_IDLE;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= '0;
                        out_last_reg   <= 1'b0;
                        out_status_reg <= STAT_DONE;
                        st_reg         <= S_IDLE;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_TOKEN)
        else $error("token length beyond buffer");

    a_seen_len: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> lal_reg != '0)
        else $error("accept seen with empty accept length");

    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_CLEAR |-> !item.ready && !out_valid_reg)
        else $error("activity during table clear");

    a_eval_src: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_EVAL |-> $past(st_reg) == S_IDLE || $past(st_reg) == S_LOOK)
        else $error("evaluation without table read");

endmodule

FILE: tb/tb_dfa_maximal_munch_tokenizer_top.sv
`timescale 1ns / 100ps

module tb_dfa_maximal_munch_tokenizer_top;
    import dmt_pkg::*;

    typedef struct packed {
        sym_t      ch;
        logic      last;
        status_t   st;
    } token_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    state_t cfg_data;

    dmt_in_if  item ();
    dmt_out_if result ();

    dfa_maximal_munch_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item.sink),
        .result   (result.source)
    );

    // predictor state
    logic [5:0]  lex_table [0:8191];
    logic [31:0] lex_accept;
    state_t      lex_state;
    state_t      lex_start;
    sym_t        lex_buf [0:31];
    int          lex_len;
    int          lex_acc_len;
    bit          lex_acc_seen;
    bit          lex_err;

    token_out_t  pending_tokens [$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_recv;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit lex_accepts(state_t s);
        return lex_accept[s];
    endfunction

    task automatic push_tok(sym_t c, logic l, status_t s);
        token_out_t t;
        t.ch = c;
        t.last = l;
        t.st = s;
        pending_tokens.insert(pending_tokens.size(), t);
    endtask

    task automatic lex_clear();
        lex_state = lex_start;
        lex_len = 0;
        lex_acc_len = 0;
        lex_acc_seen = 0;
        lex_err = 0;
    endtask

    task automatic lex_char(sym_t c);
        sym_t q [0:32];
        int n;
        int i;
        int ts;
        logic [5:0] e;
        if (lex_err)
            return;
        for (int k = 0; k < lex_len; k++)
            q[k] = lex_buf[k];
        q[lex_len] = c;
        n = lex_len + 1;
        i = lex_len;
        ts = 0;
        while (i < n)
        begin
            e = lex_table[{lex_state, q[i]}];
            if (e[5])
            begin
                lex_state = e[4:0];
                if (i + 1 - ts > 32)
                begin
                    lex_err = 1;
                    lex_len = 0;
                    lex_acc_len = 0;
                    lex_acc_seen = 0;
                    push_tok(8'd0, 1'b0, STAT_ERROR);
                    return;
                end
                if (lex_accepts(lex_state))
                begin
                    lex_acc_len = i + 1 - ts;
                    lex_acc_seen = 1;
                end
                i++;
            end
            else if (lex_acc_seen && lex_acc_len > 0)
            begin
                for (int k = 0; k < lex_acc_len; k++)
                    push_tok(q[ts + k], k + 1 == lex_acc_len, STAT_TOKEN);
                ts += lex_acc_len;
                i = ts;
                lex_state = lex_start;
                lex_acc_seen = 0;
                lex_acc_len = 0;
            end
            else
            begin
                lex_err = 1;
                lex_len = 0;
                lex_acc_len = 0;
                lex_acc_seen = 0;
                push_tok(8'd0, 1'b0, STAT_ERROR);
                return;
            end
        end
        lex_len = n - ts;
        for (int k = 0; k < lex_len; k++)
            lex_buf[k] = q[ts + k];
    endtask

    task automatic lex_end();
        if (lex_err || (lex_len > 0 && !lex_accepts(lex_state)))
            push_tok(8'd0, 1'b0, STAT_ERROR);
        else
        begin
            if (lex_acc_seen && lex_acc_len <= lex_len)
                for (int k = 0; k < lex_acc_len; k++)
                    push_tok(lex_buf[k], k + 1 == lex_acc_len, STAT_TOKEN);
            push_tok(8'd0, 1'b0, STAT_DONE);
        end
        lex_clear();
    endtask

    // one request through the input channel, predicted on acceptance
    task automatic send_request(kind_t k, state_t f, sym_t s, state_t nx, logic v, logic a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.kind <= k;
        item.from_state <= f;
        item.symbol <= s;
        item.next_state <= nx;
        item.entry_valid <= v;
        item.accepting <= a;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        case (k)
            KIND_LOAD:   lex_table[{f, s}] = v ? {1'b1, nx} : 6'd0;
            KIND_ACCEPT: lex_accept[f] = a;
            KIND_CHAR:   lex_char(s);
            default:     lex_end();
        endcase
    endtask

    task automatic load(state_t f, sym_t s, state_t nx, logic v = 1'b1);
        send_request(KIND_LOAD, f, s, nx, v, 1'($urandom_range(1)));
    endtask

    task automatic set_accept(state_t f, logic a);
        send_request(KIND_ACCEPT, f, sym_t'($urandom), state_t'($urandom),
                     1'($urandom_range(1)), a);
    endtask

    task automatic send_char(sym_t s);
        send_request(KIND_CHAR, state_t'($urandom), s, state_t'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_end();
        send_request(KIND_END, state_t'($urandom), sym_t'($urandom), state_t'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_start(state_t s);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        lex_start = s;
    endtask

    always @(posedge clk)
    begin
        if (result.valid && result.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected result char=%0h status=%0d", result.out_char, result.status);
                errors++;
            end
            else
            begin
                token_out_t t;
                t = pending_tokens.pop_front();
                if (result.out_char !== t.ch)
                begin
                    $error("out_char expected %0h actual %0h", t.ch, result.out_char);
                    errors++;
                end
                if (result.token_last !== t.last)
                begin
                    $error("token_last expected %0b actual %0b", t.last, result.token_last);
                    errors++;
                end
                if (result.status !== t.st)
                begin
                    $error("status expected %0d actual %0d", t.st, result.status);
                    errors++;
                end
            end
        end
        result.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // identifiers: state 1 after a-f, accepting; digits: state 2 accepting; '-' 3, '!' 4
    task automatic build_lexer();
        for (int c = 8'h61; c <= 8'h66; c++)
        begin
            load(lex_start, sym_t'(c), 5'd1);
            load(5'd1, sym_t'(c), 5'd1);
        end
        load(lex_start, 8'h30, 5'd2);
        load(5'd2, 8'h30, 5'd2);
        load(5'd2, 8'h31, 5'd2);
        load(lex_start, 8'h2d, 5'd3);
        load(5'd3, 8'h21, 5'd4);
        set_accept(5'd1, 1'b1);
        set_accept(5'd2, 1'b1);
        set_accept(5'd4, 1'b1);
        set_accept(5'd3, 1'b0);
    endtask

    function automatic sym_t lex_sym();
        sym_t set [0:10] = '{8'h61, 8'h62, 8'h66, 8'h30, 8'h31, 8'h2d, 8'h21,
                              8'h2d, 8'h30, 8'h61, 8'h20};
        return set[$urandom_range(10)];
    endfunction

    task automatic test_directed();
        write_start(5'd0);
        build_lexer();
        send_char(8'h61); send_char(8'h62); send_char(8'h30);
        send_char(8'h2d); send_char(8'h21); send_end();
        send_char(8'h2d); send_end();
        send_char(8'hff); send_char(8'h61); send_end();
        send_end();
        load(5'd31, 8'hff, 5'd31);
        load(5'd31, 8'hff, 5'd31, 1'b0);
        set_accept(5'd31, 1'b1);
        set_accept(5'd31, 1'b0);
    endtask

    task automatic test_overflow();
        for (int k = 0; k < 34; k++)
            send_char(8'h61);
        send_end();
        for (int k = 0; k < 32; k++)
            send_char(8'h62);
        send_end();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
        begin
            int r;
            r = $urandom_range(99);
            if (r < 75)
                send_char(lex_sym());
            else if (r < 85)
                send_end();
            else if (r < 90)
                send_char(sym_t'($urandom));
            else if (r < 95)
                load(state_t'($urandom), sym_t'($urandom), state_t'($urandom),
                     1'($urandom_range(1)));
            else
                set_accept(state_t'($urandom), 1'($urandom_range(1)));
        end
        send_end();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
            end
            begin
                for (int k = 0; k < 40; k++)
                    send_char(sym_t'(8'h61 + (k % 2)));
                send_end();
                drain();
            end
        join
        drain();
    endtask

    task automatic test_start_state();
        write_start(5'd31);
        build_lexer();
        test_random(15);
        write_start(5'd0);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        item.valid = 1'b0;
        item.kind = KIND_LOAD;
        item.from_state = '0;
        item.symbol = '0;
        item.next_state = '0;
        item.entry_valid = 1'b0;
        item.accepting = 1'b0;
        result.ready = 1'b0;
        for (int k = 0; k < 8192; k++)
            lex_table[k] = 6'd0;
        lex_accept = '0;
        lex_start = '0;
        lex_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_overflow();
        test_random(20);
        send_idle_pct = 68;
        test_random(25);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        test_random(25);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        test_random(25);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_start_state();
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
